// ===== rtl/ed_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed_pkg
// Shared codes and types for the edit distance engine.
// ----------------------------------------------------------------------------
package ed_pkg;

    localparam int unsigned SYM_W  = 8;
    localparam int unsigned ACT_W  = 2;
    localparam int unsigned DIST_W = 9;

    localparam logic [ACT_W-1:0] ACT_PATTERN = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TEXT    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FINISH  = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] sym;
    } t_wave_ctl;

endpackage

// ===== rtl/ed_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed_in_if
// Input channel: one action and one symbol byte per beat.
// ----------------------------------------------------------------------------
interface ed_in_if;

    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] symbol;

    modport source (output valid, output action, output symbol, input ready);
    modport sink   (input valid, input action, input symbol, output ready);

endinterface

// ===== rtl/ed_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed_out_if
// Result channel: edit distance and error flag per beat.
// ----------------------------------------------------------------------------
interface ed_out_if;

    logic       valid;
    logic       ready;
    logic [8:0] distance;
    logic       error;

    modport source (output valid, output distance, output error, input ready);
    modport sink   (input valid, input distance, input error, output ready);

endinterface

// ===== rtl/ed_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed_cell
// One column of the cost table: holds a pattern byte and its cost, updates
// the cost as a text wave passes and hands the wave to the next cell.
// ----------------------------------------------------------------------------
module ed_cell
    import ed_pkg::*;
#(
    parameter int unsigned CW = 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_wave_ctl             i_wave,
    input  logic [CW-1:0]         i_diag,
    input  logic [CW-1:0]         i_left,
    input  logic                  i_load,
    input  logic [SYM_W-1:0]      i_pat,
    input  logic [CW-1:0]         i_load_cost,
    input  logic                  i_clear,
    output t_wave_ctl             o_wave,
    output logic [CW-1:0]         o_diag,
    output logic [CW-1:0]         o_new
);

    logic             r_active;
    logic [SYM_W-1:0] r_pat;
    logic [CW-1:0]    r_cost;
    t_wave_ctl        r_wave;
    logic [CW-1:0]    r_diag;
    logic [CW-1:0]    r_new;

    logic [CW-1:0]    w_min;
    logic [CW-1:0]    w_calc;

    always_comb begin
        w_min = (r_cost < i_diag) ? r_cost : i_diag;
        if (i_left < w_min) begin
            w_min = i_left;
        end
        w_calc = (i_wave.sym == r_pat) ? i_diag : CW'(w_min + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_wave.valid <= 1'b0;
        end else begin
            r_wave.valid <= i_wave.valid;
            if (i_clear) begin
                r_active <= 1'b0;
            end else if (i_load) begin
                r_active <= 1'b1;
            end
        end
        r_wave.sym <= i_wave.sym;
        if (i_load) begin
            r_pat  <= i_pat;
            r_cost <= i_load_cost;
        end
        if (r_active && i_wave.valid) begin
            r_diag <= r_cost;
            r_new  <= w_calc;
            r_cost <= w_calc;
        end else begin
            r_diag <= i_diag;
            r_new  <= i_left;
        end
    end

    assign o_wave = r_wave;
    assign o_diag = r_diag;
    assign o_new  = r_new;

endmodule

// ===== rtl/edit_distance_engine.sv =====
`timescale 1ns / 1ps
// Result: a finish beat's result is registered and shown in the cycle after it is accepted.
// Throughput: one pattern or text beat per cycle; each text beat walks the
// row of MAX_LEN cells, one cell per cycle, so a finish waits after the last
// text beat until the row has drained.
// Reset: synchronous, active low; clears counters, error flag, cell and output
// valid flags. Finish clears counters, error flag and cell active flags.
// ----------------------------------------------------------------------------
// edit_distance_engine
// Levenshtein edit distance over a systolic row of cells, one pattern byte
// per cell, with a registered result beat.
// ----------------------------------------------------------------------------
module edit_distance_engine
    import ed_pkg::*;
#(
    parameter int unsigned MAX_LEN = 256
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ed_in_if.sink    i_in,
    ed_out_if.source o_out
);

    localparam int unsigned CW = $clog2(MAX_LEN + 1);
    localparam int unsigned FW = $clog2(MAX_LEN + 2);

    logic [CW-1:0]     r_pcount;
    logic [CW-1:0]     r_tcount;
    logic              r_err;
    logic [CW-1:0]     r_tail;
    logic [FW-1:0]     r_inflight;
    t_wave_ctl         r_in_wave;
    logic [CW-1:0]     r_in_diag;
    logic [CW-1:0]     r_in_new;
    logic              r_out_valid;
    logic [DIST_W-1:0] r_dist;
    logic              r_oerr;

    logic              w_fin_ok;
    logic              w_acc;
    logic              w_load;
    logic              w_launch;
    logic              w_finish;
    logic              w_drop;
    logic              w_exit;

    t_wave_ctl         w_wave [MAX_LEN+1];
    logic [CW-1:0]     w_diag [MAX_LEN+1];
    logic [CW-1:0]     w_new  [MAX_LEN+1];

    assign w_fin_ok   = (r_inflight == '0) && (!r_out_valid || o_out.ready);
    assign i_in.ready = (i_in.action == ACT_FINISH) ? w_fin_ok : 1'b1;
    assign w_acc      = i_in.valid && i_in.ready;

    always_comb begin
        w_load   = 1'b0;
        w_launch = 1'b0;
        w_finish = 1'b0;
        w_drop   = 1'b0;
        unique case (i_in.action)
            ACT_PATTERN: begin
                if (r_tcount != '0 || r_pcount >= CW'(MAX_LEN)) begin
                    w_drop = w_acc;
                end else begin
                    w_load = w_acc;
                end
            end
            ACT_TEXT: begin
                if (r_tcount >= CW'(MAX_LEN)) begin
                    w_drop = w_acc;
                end else begin
                    w_launch = w_acc;
                end
            end
            ACT_FINISH: w_finish = w_acc;
            default: ;
        endcase
    end

    assign w_exit = w_wave[MAX_LEN].valid;

    assign w_wave[0] = r_in_wave;
    assign w_diag[0] = r_in_diag;
    assign w_new[0]  = r_in_new;

    for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
        ed_cell #(
            .CW (CW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_wave      (w_wave[j]),
            .i_diag      (w_diag[j]),
            .i_left      (w_new[j]),
            .i_load      (w_load && (r_pcount == CW'(j))),
            .i_pat       (i_in.symbol),
            .i_load_cost (CW'(j + 1)),
            .i_clear     (w_finish),
            .o_wave      (w_wave[j+1]),
            .o_diag      (w_diag[j+1]),
            .o_new       (w_new[j+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount        <= '0;
            r_tcount        <= '0;
            r_err           <= 1'b0;
            r_tail          <= '0;
            r_inflight      <= '0;
            r_in_wave.valid <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_in_wave.valid <= w_launch;
            r_inflight      <= FW'(r_inflight + FW'(w_launch) - FW'(w_exit));
            if (w_finish) begin
                r_pcount    <= '0;
                r_tcount    <= '0;
                r_err       <= 1'b0;
                r_tail      <= '0;
                r_out_valid <= 1'b1;
            end else begin
                if (w_drop) begin
                    r_err <= 1'b1;
                end
                if (w_load) begin
                    r_pcount <= CW'(r_pcount + 1'b1);
                    r_tail   <= CW'(r_pcount + 1'b1);
                end else if (w_exit) begin
                    r_tail <= w_new[MAX_LEN];
                end
                if (w_launch) begin
                    r_tcount <= CW'(r_tcount + 1'b1);
                end
                if (o_out.ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
        r_in_wave.sym <= i_in.symbol;
        r_in_diag     <= r_tcount;
        r_in_new      <= CW'(r_tcount + 1'b1);
        if (w_finish) begin
            r_dist <= DIST_W'(r_tail);
            r_oerr <= r_err;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.distance = r_dist;
    assign o_out.error    = r_oerr;

    a_fin_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |-> (r_inflight == '0))
        else $error("finish accepted with text beats still in the row");

    a_fin_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> r_out_valid)
        else $error("finish beat gave no result");

    a_idle_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tcount == '0) |-> (r_inflight == '0))
        else $error("waves in flight with no text beats counted");

    a_inflight_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= FW'(MAX_LEN + 1))
        else $error("in-flight count beyond row depth");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!w_exit && !r_in_wave.valid))
        else $error("pattern load while a wave is in the row");

endmodule
